/* hw/rtl/ucc_pkg.sv */
// ucc_pkg: beat types, verdict codes, decode and case-fold functions for the
// caseless utf-8 comparator; no dependencies
`default_nettype none
package ucc_pkg;

    typedef struct packed {
        logic        last;
        logic [31:0] bytes_b;
        logic [31:0] bytes_a;
    } ucc_in_t;

    typedef struct packed {
        logic       done_res;
        logic [1:0] verdict;
        logic [2:0] advance_b;
        logic [2:0] advance_a;
    } ucc_out_t;

    localparam logic [1:0] VERDICT_EQUAL   = 2'd0;
    localparam logic [1:0] VERDICT_DIFFER  = 2'd1;
    localparam logic [1:0] VERDICT_INVALID = 2'd2;

    typedef struct packed {
        logic        invalid;
        logic [2:0]  len;
        logic [15:0] cp;
    } ucc_dec_t;

    // fold result: second code point is zero for single folds
    typedef struct packed {
        logic        two;
        logic [15:0] f0;
        logic [15:0] f1;
    } ucc_fold_t;

    function automatic ucc_dec_t ucc_decode(input logic [31:0] w);
        ucc_dec_t   d;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        b0 = w[7:0];
        b1 = w[15:8];
        b2 = w[23:16];
        b3 = w[31:24];
        d.invalid = 1'b0;
        d.len     = 3'd1;
        d.cp      = {8'h00, b0};
        if (b0[7:6] == 2'b10) begin
            d.invalid = 1'b1;
        end else if (b0[7:6] != 2'b11) begin
            d.len = (b0 == 8'h00) ? 3'd0 : 3'd1;
        end else if (!b0[5]) begin
            d.len     = 3'd2;
            d.invalid = (b1[7:6] != 2'b10);
            d.cp      = {5'd0, b0[4:0], b1[5:0]};
        end else if (!b0[4]) begin
            d.len     = 3'd3;
            d.invalid = (b1[7:6] != 2'b10) || (b2[7:6] != 2'b10);
            d.cp      = {b0[3:0], b1[5:0], b2[5:0]};
        end else begin
            d.len     = 3'd4;
            d.invalid = b0[3] || (b1[7:6] != 2'b10) || (b2[7:6] != 2'b10)
                        || (b3[7:6] != 2'b10);
            d.cp      = {b1[3:0], b2[5:0], b3[5:0]};
        end
        return d;
    endfunction

    function automatic ucc_fold_t ucc_fold(input logic [15:0] c);
        ucc_fold_t f;
        f.two = 1'b0;
        f.f0  = c;
        f.f1  = 16'h0000;
        if (c < 16'h0041 || (c >= 16'h005B && c <= 16'h00BF)) begin
            if (c == 16'h00B5) f.f0 = 16'h03BC;
        end else if (c <= 16'h005A || (c >= 16'h00C0 && c <= 16'h00DE && c != 16'h00D7)) begin
            f.f0 = c + 16'd32;
        end else if ((c >= 16'h0100 && c <= 16'h012F) || (c >= 16'h0132 && c <= 16'h0137) ||
                     (c >= 16'h014A && c <= 16'h0177) || (c >= 16'h01DE && c <= 16'h01EF) ||
                     (c >= 16'h01F8 && c <= 16'h021F) || (c >= 16'h0222 && c <= 16'h0233) ||
                     (c >= 16'h0246 && c <= 16'h024F)) begin
            f.f0 = c | 16'h0001;
        end else if ((c >= 16'h0139 && c <= 16'h0148) ||
                     (c >= 16'h01CD && c <= 16'h01DC)) begin
            f.f0 = c + {15'd0, c[0]};
        end else begin
            case (c)
                16'h0178: f.f0 = 16'h00FF;
                16'h0179: f.f0 = 16'h017A;
                16'h017B: f.f0 = 16'h017C;
                16'h017D: f.f0 = 16'h017E;
                16'h017F: f.f0 = 16'h0073;
                16'h0181: f.f0 = 16'h0253;
                16'h0182: f.f0 = 16'h0183;
                16'h0184: f.f0 = 16'h0185;
                16'h0186: f.f0 = 16'h0254;
                16'h0187: f.f0 = 16'h0188;
                16'h0189: f.f0 = 16'h0256;
                16'h018A: f.f0 = 16'h0257;
                16'h018B: f.f0 = 16'h018C;
                16'h018E: f.f0 = 16'h01DD;
                16'h018F: f.f0 = 16'h0259;
                16'h0190: f.f0 = 16'h025B;
                16'h0191: f.f0 = 16'h0192;
                16'h0193: f.f0 = 16'h0260;
                16'h0194: f.f0 = 16'h0263;
                16'h0196: f.f0 = 16'h0269;
                16'h0197: f.f0 = 16'h0268;
                16'h0198: f.f0 = 16'h0199;
                16'h019C: f.f0 = 16'h026F;
                16'h019D: f.f0 = 16'h0272;
                16'h019F: f.f0 = 16'h0275;
                16'h01A0: f.f0 = 16'h01A1;
                16'h01A2: f.f0 = 16'h01A3;
                16'h01A4: f.f0 = 16'h01A5;
                16'h01A6: f.f0 = 16'h0280;
                16'h01A7: f.f0 = 16'h01A8;
                16'h01A9: f.f0 = 16'h0283;
                16'h01AC: f.f0 = 16'h01AD;
                16'h01AE: f.f0 = 16'h0288;
                16'h01AF: f.f0 = 16'h01B0;
                16'h01B1: f.f0 = 16'h028A;
                16'h01B2: f.f0 = 16'h028B;
                16'h01B3: f.f0 = 16'h01B4;
                16'h01B5: f.f0 = 16'h01B6;
                16'h01B7: f.f0 = 16'h0292;
                16'h01B8: f.f0 = 16'h01B9;
                16'h01BC: f.f0 = 16'h01BD;
                16'h01C4: f.f0 = 16'h01C6;
                16'h01C5: f.f0 = 16'h01C6;
                16'h01C7: f.f0 = 16'h01C9;
                16'h01C8: f.f0 = 16'h01C9;
                16'h01CA: f.f0 = 16'h01CC;
                16'h01F1: f.f0 = 16'h01F3;
                16'h01F2: f.f0 = 16'h01F3;
                16'h01F4: f.f0 = 16'h01F5;
                16'h01F6: f.f0 = 16'h0195;
                16'h01F7: f.f0 = 16'h01BF;
                16'h0220: f.f0 = 16'h019E;
                16'h023A: f.f0 = 16'h2C65;
                16'h023B: f.f0 = 16'h023C;
                16'h023D: f.f0 = 16'h019A;
                16'h023E: f.f0 = 16'h2C66;
                16'h0241: f.f0 = 16'h0242;
                16'h0243: f.f0 = 16'h0180;
                16'h0244: f.f0 = 16'h0289;
                16'h0245: f.f0 = 16'h028C;
                16'h00DF: begin f.two = 1'b1; f.f0 = 16'h0073; f.f1 = 16'h0073; end
                16'h0130: begin f.two = 1'b1; f.f0 = 16'h0069; f.f1 = 16'h0307; end
                16'h0149: begin f.two = 1'b1; f.f0 = 16'h02BC; f.f1 = 16'h006E; end
                16'h01F0: begin f.two = 1'b1; f.f0 = 16'h006A; f.f1 = 16'h030C; end
                default: f.f0 = c;
            endcase
        end
        return f;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/utf8_caseless_compare.sv */
// utf8_caseless_compare: top level, input register, decode/fold/compare,
// output register; depends on ucc_pkg
`default_nettype none
// Compares two utf-8 strings without regard to case, one character pair per
// beat. Each input beat carries the next four bytes of each string; the result
// beat reports how many bytes each character took (advance the streams by
// these), the verdict so far and whether it is final. A mismatch or invalid
// sequence is held, with zero advances, until the beat marked last, after
// which a new comparison starts. Throughput is one beat per cycle while the
// receiver takes results. A beat that is accepted is captured in the input
// register, and its result is loaded into the result register as soon as
// that register is empty or being drained. Each stage moves whenever the
// stage ahead of it is empty or being drained, so full rate holds with no
// idle cycles while the receiver takes results.
module utf8_caseless_compare
    import ucc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire ucc_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output ucc_out_t      m_data
);

    logic       in_valid_reg;
    ucc_in_t    in_data_reg;
    logic       out_valid_reg;
    ucc_out_t   out_data_reg;
    logic       halted_reg, halted_next;
    logic [1:0] held_reg, held_next;
    ucc_out_t   res;
    logic       out_load;
    logic       in_load;
    ucc_dec_t   da, db;
    ucc_fold_t  fa, fb;

    assign out_load = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || out_load;
    assign in_load  = s_valid && s_ready;

    // decode, fold and compare on the registered beat
    always_comb begin
        da = ucc_decode(in_data_reg.bytes_a);
        db = ucc_decode(in_data_reg.bytes_b);
        fa = ucc_fold(da.cp);
        fb = ucc_fold(db.cp);
        res = '0;
        if (halted_reg) begin
            res.verdict = held_reg;
        end else if (da.invalid || db.invalid) begin
            res.verdict = VERDICT_INVALID;
        end else begin
            res.advance_a = da.len;
            res.advance_b = db.len;
            res.verdict   = (fa != fb) ? VERDICT_DIFFER : VERDICT_EQUAL;
        end
        res.done_res = halted_reg || (res.verdict != VERDICT_EQUAL) || in_data_reg.last;
        halted_next = halted_reg;
        held_next   = held_reg;
        if (!halted_reg && res.verdict != VERDICT_EQUAL) begin
            halted_next = 1'b1;
            held_next   = res.verdict;
        end
        if (in_data_reg.last) begin
            halted_next = 1'b0;
            held_next   = VERDICT_EQUAL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            halted_reg    <= 1'b0;
            held_reg      <= VERDICT_EQUAL;
        end else begin
            if (in_load) begin
                in_valid_reg <= 1'b1;
            end else if (out_load) begin
                in_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
                halted_reg    <= halted_next;
                held_reg      <= held_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_data_reg <= s_data;
        end
        if (out_load) begin
            out_data_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
`default_nettype wire

/* verif/tb.sv */
// tb: self-checking bench for utf8_caseless_compare, random and directed
// character pairs checked against an in-bench fold/compare predictor
// depends on ucc_pkg and the utf8_caseless_compare rtl
`default_nettype none

module tb;
    import ucc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;

    // caseless compare predictor with its own copy of the halt state
    class fold_scoreboard;
        bit         halted;
        logic [1:0] held;
        ucc_out_t   pending[$];
        int         errors;
        int         shown;

        function void clear();
            halted = 1'b0;
            held = VERDICT_EQUAL;
            pending.delete();
            errors = 0;
            shown = 0;
        endfunction

        // returns byte count, -1 when invalid
        function int utf8_len(input logic [31:0] w, output logic [15:0] cp);
            logic [7:0] b;
            int n;
            int i;
            b = w[7:0];
            cp = {8'h00, b};
            if (b[7:6] == 2'b10) return -1;
            if (b[7:6] != 2'b11) return (b == 8'h00) ? 0 : 1;
            if (!b[5]) begin
                n = 1;
                cp = {11'd0, b[4:0]};
            end else if (!b[4]) begin
                n = 2;
                cp = {12'd0, b[3:0]};
            end else begin
                if (b[3]) return -1;
                n = 3;
                cp = {13'd0, b[2:0]};
            end
            for (i = 1; i <= n; i++) begin
                b = w[8*i +: 8];
                if (b[7:6] != 2'b10) return -1;
                cp = {cp[9:0], b[5:0]};
            end
            return n + 1;
        endfunction

        function int single_map(input logic [15:0] c, output logic [15:0] m);
            logic [15:0] tbl[61][2] = '{
                '{16'h00B5, 16'h03BC}, '{16'h0178, 16'h00FF}, '{16'h0179, 16'h017A},
                '{16'h017B, 16'h017C}, '{16'h017D, 16'h017E}, '{16'h017F, 16'h0073},
                '{16'h0181, 16'h0253}, '{16'h0182, 16'h0183}, '{16'h0184, 16'h0185},
                '{16'h0186, 16'h0254}, '{16'h0187, 16'h0188}, '{16'h0189, 16'h0256},
                '{16'h018A, 16'h0257}, '{16'h018B, 16'h018C}, '{16'h018E, 16'h01DD},
                '{16'h018F, 16'h0259}, '{16'h0190, 16'h025B}, '{16'h0191, 16'h0192},
                '{16'h0193, 16'h0260}, '{16'h0194, 16'h0263}, '{16'h0196, 16'h0269},
                '{16'h0197, 16'h0268}, '{16'h0198, 16'h0199}, '{16'h019C, 16'h026F},
                '{16'h019D, 16'h0272}, '{16'h019F, 16'h0275}, '{16'h01A0, 16'h01A1},
                '{16'h01A2, 16'h01A3}, '{16'h01A4, 16'h01A5}, '{16'h01A6, 16'h0280},
                '{16'h01A7, 16'h01A8}, '{16'h01A9, 16'h0283}, '{16'h01AC, 16'h01AD},
                '{16'h01AE, 16'h0288}, '{16'h01AF, 16'h01B0}, '{16'h01B1, 16'h028A},
                '{16'h01B2, 16'h028B}, '{16'h01B3, 16'h01B4}, '{16'h01B5, 16'h01B6},
                '{16'h01B7, 16'h0292}, '{16'h01B8, 16'h01B9}, '{16'h01BC, 16'h01BD},
                '{16'h01C4, 16'h01C6}, '{16'h01C5, 16'h01C6}, '{16'h01C7, 16'h01C9},
                '{16'h01C8, 16'h01C9}, '{16'h01CA, 16'h01CC}, '{16'h01F1, 16'h01F3},
                '{16'h01F2, 16'h01F3}, '{16'h01F4, 16'h01F5}, '{16'h01F6, 16'h0195},
                '{16'h01F7, 16'h01BF}, '{16'h0220, 16'h019E}, '{16'h023A, 16'h2C65},
                '{16'h023B, 16'h023C}, '{16'h023D, 16'h019A}, '{16'h023E, 16'h2C66},
                '{16'h0241, 16'h0242}, '{16'h0243, 16'h0180}, '{16'h0244, 16'h0289},
                '{16'h0245, 16'h028C}};
            m = c;
            foreach (tbl[k]) if (tbl[k][0] == c) begin
                m = tbl[k][1];
                return 1;
            end
            return 0;
        endfunction

        // folded form packed as {two, second, first}, second zero for one-point folds
        function logic [32:0] fold_char(input logic [15:0] c);
            logic [15:0] m;
            if (c < 16'h0041 || (c >= 16'h005B && c <= 16'h00BF))
                return {17'd0, (c == 16'h00B5) ? 16'h03BC : c};
            if (c <= 16'h005A || (c >= 16'h00C0 && c <= 16'h00DE && c != 16'h00D7))
                return {17'd0, c + 16'd32};
            if ((c >= 16'h0100 && c <= 16'h012F) || (c >= 16'h0132 && c <= 16'h0137) ||
                (c >= 16'h014A && c <= 16'h0177) || (c >= 16'h01DE && c <= 16'h01EF) ||
                (c >= 16'h01F8 && c <= 16'h021F) || (c >= 16'h0222 && c <= 16'h0233) ||
                (c >= 16'h0246 && c <= 16'h024F))
                return {17'd0, c | 16'h0001};
            if ((c >= 16'h0139 && c <= 16'h0148) || (c >= 16'h01CD && c <= 16'h01DC))
                return {17'd0, c + {15'd0, c[0]}};
            if (single_map(c, m)) return {17'd0, m};
            case (c)
                16'h00DF: return {1'b1, 16'h0073, 16'h0073};
                16'h0130: return {1'b1, 16'h0307, 16'h0069};
                16'h0149: return {1'b1, 16'h006E, 16'h02BC};
                16'h01F0: return {1'b1, 16'h030C, 16'h006A};
                default:  return {17'd0, c};
            endcase
        endfunction

        function void note_pair(input ucc_in_t p);
            ucc_out_t r;
            logic [15:0] ca;
            logic [15:0] cb;
            int la;
            int lb;
            r = '0;
            if (halted) begin
                r.verdict = held;
                r.done_res = 1'b1;
            end else begin
                la = utf8_len(p.bytes_a, ca);
                lb = (la < 0) ? -1 : utf8_len(p.bytes_b, cb);
                if (la < 0 || lb < 0) begin
                    r.verdict = VERDICT_INVALID;
                end else begin
                    r.advance_a = la[2:0];
                    r.advance_b = lb[2:0];
                    r.verdict = (fold_char(ca) != fold_char(cb)) ? VERDICT_DIFFER
                                                                 : VERDICT_EQUAL;
                end
                if (r.verdict != VERDICT_EQUAL) begin
                    halted = 1'b1;
                    held = r.verdict;
                end
                r.done_res = (r.verdict != VERDICT_EQUAL) || p.last;
            end
            if (p.last) begin
                halted = 1'b0;
                held = VERDICT_EQUAL;
            end
            pending.push_back(r);
        endfunction

        function void check_result(input ucc_out_t got);
            ucc_out_t want;
            if (pending.size() == 0) begin
                errors++;
                if (shown++ < 10) $display("unexpected result beat %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.advance_a !== want.advance_a || got.advance_b !== want.advance_b ||
                got.verdict !== want.verdict || got.done_res !== want.done_res) begin
                errors++;
                if (shown++ < 10)
                    $display("mismatch: exp adv %0d/%0d v%0d d%0d, got adv %0d/%0d v%0d d%0d",
                             want.advance_a, want.advance_b, want.verdict, want.done_res,
                             got.advance_a, got.advance_b, got.verdict, got.done_res);
            end
        endfunction
    endclass

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    ucc_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    ucc_out_t m_data;

    fold_scoreboard sb;
    bit   src_idle_en;        // sender gaps enabled
    bit   sink_idle_en;       // receiver stalls enabled
    bit   hold_sink;          // long receiver hold-off
    int   quiet_cycles;

    utf8_caseless_compare DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // scoreboard taps on accepted beats, both sides
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_pair(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
        end
    end

    // receiver: random stalls, or a hold-off when asked
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_sink) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(sink_idle_en && $urandom_range(99) < 20);
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn || hold_sink) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    // present one beat and hold it until accepted, with an optional gap first
    // ready is looked at mid-cycle, where it is settled for the coming edge
    task automatic send_pair(input logic [31:0] a, input logic [31:0] b, input bit lst);
        while (src_idle_en && $urandom_range(99) < 20) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{last: lst, bytes_b: b, bytes_a: a};
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic pause_sender();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    // utf-8 encoding of a code point, always well formed, random trailing bytes
    function automatic logic [31:0] encode_cp(input logic [20:0] cp);
        logic [31:0] w;
        w = $urandom;
        if (cp < 21'h80) begin
            w[7:0] = cp[7:0];
        end else if (cp < 21'h800) begin
            w[15:0] = {2'b10, cp[5:0], 3'b110, cp[10:6]};
        end else if (cp < 21'h10000) begin
            w[23:0] = {2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
        end else begin
            w = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12], 5'b11110, cp[20:18]};
        end
        return w;
    endfunction

    // code points weighted toward the regions with case folding
    function automatic logic [20:0] pick_cp();
        case ($urandom_range(9))
            0, 1:    return 21'($urandom_range(8'h7F, 1));
            2, 3:    return 21'($urandom_range(16'h00FF, 16'h0080));
            4, 5, 6: return 21'($urandom_range(16'h024F, 16'h0100));
            7:       return 21'($urandom_range(16'hFFFF, 16'h0250));
            8:       return 21'($urandom_range(21'h10FFFF, 21'h10000));
            default: return 21'h0;
        endcase
    endfunction

    // partner of a character: often its other case, so strings keep matching
    function automatic logic [20:0] partner_cp(input logic [20:0] c);
        if (c >= 21'h41 && c <= 21'h5A) return c + 21'd32;
        if (c >= 21'h61 && c <= 21'h7A) return c - 21'd32;
        if (c >= 21'hC0 && c <= 21'hDE && c != 21'hD7) return c + 21'd32;
        if (c >= 21'h100 && c <= 21'h12F) return c ^ 21'd1;
        if (c == 21'hB5) return 21'h3BC;
        return c;
    endfunction

    task automatic run_string(input int len);
        logic [20:0] c;
        logic [31:0] a;
        logic [31:0] b;
        int i;
        for (i = 0; i < len; i++) begin
            c = pick_cp();
            a = encode_cp(c);
            case ($urandom_range(19))
                0:       b = encode_cp(pick_cp());
                1:       b = $urandom;                      // noise
                2:       begin b = encode_cp(partner_cp(c)); a[15:14] = 2'($urandom); end
                default: b = encode_cp(partner_cp(c));
            endcase
            if ($urandom_range(40) == 0) a = $urandom;
            send_pair(a, b, i == len - 1);
        end
    endtask

    initial begin
        int n;
        int hold;
        sb = new();
        sb.clear();
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        hold_sink    = 1'b0;
        quiet_cycles = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: nul, ascii case, latin-1, micro and multiplication signs
        send_pair(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_pair(32'h0000_0041, 32'h0000_0061, 1'b0);
        send_pair(32'h0000_B5C2, 32'h0000_BCCE, 1'b0);
        send_pair(32'h0000_97C3, 32'h0000_B7C3, 1'b1);   // times vs divide differ
        send_pair(32'h0000_0041, 32'h0000_0041, 1'b1);   // new comparison after the release, equal
        // sharp s, dotted capital i, alternating-case ranges, 4-byte truncation
        send_pair(32'h0000_9FC3, 32'h0000_9FC3, 1'b0);
        send_pair(32'h0000_B0C4, 32'h0000_B1C4, 1'b0);
        send_pair(32'h0000_B9C4, 32'h0000_BAC4, 1'b0);
        send_pair(32'h8080_80F0, 32'h0000_0000, 1'b0);   // truncates to code point 0
        send_pair(32'h0080_80C0, 32'h0000_0000, 1'b1);   // overlong nul
        // invalid forms: stray continuation, f8 lead, bad continuation, b side
        send_pair(32'h0000_0080, 32'h0000_0041, 1'b1);
        send_pair(32'hFFFF_FFF8, 32'h0000_0041, 1'b1);
        send_pair(32'h0000_41C3, 32'h0000_0041, 1'b1);
        send_pair(32'h0000_0041, 32'h0000_00FF, 1'b0);
        send_pair(32'h0000_0041, 32'h0000_0041, 1'b0);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_pair(32'h8080_8FEF, 32'h8080_8FEF, 1'b1);
        pause_sender();

        // random, with gaps on both sides
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        n = 0;
        while (n < 780) begin
            hold = $urandom_range(12, 1);
            run_string(hold);
            n += hold;
            if (n > 250 && n < 270) begin
                // receiver holds off while the sender keeps offering
                hold_sink = 1'b1;
                fork
                    begin
                        repeat (60) @(posedge aclk);
                        hold_sink = 1'b0;
                    end
                    run_string(8);
                join
                n += 8;
                pause_sender();
            end
            if (n > 450 && n < 580) begin
                // stretch without idling
                src_idle_en  = 1'b0;
                sink_idle_en = 1'b0;
            end else begin
                src_idle_en  = 1'b1;
                sink_idle_en = 1'b1;
            end
        end
        s_valid <= 1'b0;

        n = 0;
        while (sb.pending.size() != 0 && n < 10000) begin
            @(posedge aclk);
            n++;
        end
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
